// ----- hdl/hphl_pkg.sv -----
// Package: types, constants and CORDIC table for the hand-position heading law.
package hphl_pkg;

  localparam int CordicTableLen = 24;
  localparam logic signed [33:0] CordicX0 = 34'sd652032874;
  localparam logic [29:0] RadToBaQ16 = 30'd683565276;
  localparam logic signed [47:0] IntMax48 = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] IntMin48 = 48'sh8000_0000_0000;

  typedef enum logic [1:0] {
    CFG_LOOKAHEAD = 2'd0,
    CFG_PROP_GAIN = 2'd1,
    CFG_INT_GAIN  = 2'd2
  } cfg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CORDIC,
    ST_DSIN,
    ST_EY,
    ST_INC,
    ST_INTEG,
    ST_PROP,
    ST_IHI,
    ST_ILO,
    ST_U,
    ST_UCL,
    ST_UCH,
    ST_WKL,
    ST_WKH,
    ST_OUT
  } state_t;

  function automatic logic [29:0] atan_turn32(input logic [4:0] i);
    logic [29:0] r;
    begin
      unique case (i)
        5'd0:  r = 30'h20000000;
        5'd1:  r = 30'h12E4051E;
        5'd2:  r = 30'h09FB385B;
        5'd3:  r = 30'h051111D4;
        5'd4:  r = 30'h028B0D43;
        5'd5:  r = 30'h0145D7E1;
        5'd6:  r = 30'h00A2F61E;
        5'd7:  r = 30'h00517C55;
        5'd8:  r = 30'h0028BE53;
        5'd9:  r = 30'h00145F2F;
        5'd10: r = 30'h000A2F98;
        5'd11: r = 30'h000517CC;
        5'd12: r = 30'h00028BE6;
        5'd13: r = 30'h000145F3;
        5'd14: r = 30'h0000A2FA;
        5'd15: r = 30'h0000517D;
        5'd16: r = 30'h000028BE;
        5'd17: r = 30'h0000145F;
        5'd18: r = 30'h00000A30;
        5'd19: r = 30'h00000518;
        5'd20: r = 30'h0000028C;
        5'd21: r = 30'h00000146;
        5'd22: r = 30'h000000A3;
        5'd23: r = 30'h00000051;
        default: r = 30'h0;
      endcase
      return r;
    end
  endfunction

endpackage

// ----- hdl/hphl_if.sv -----
// Valid/ready channel interfaces for the input and result transactions.
interface hphl_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] vehicle_heading;
  logic signed [15:0] path_bearing;
  logic signed [31:0] cross_track;
  logic        [23:0] elapsed_time;
  modport source (output valid, vehicle_heading, path_bearing, cross_track, elapsed_time,
                  input ready);
  modport sink   (input valid, vehicle_heading, path_bearing, cross_track, elapsed_time,
                  output ready);
endinterface

interface hphl_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] desired_heading;
  logic               integral_saturated;
  modport source (output valid, desired_heading, integral_saturated, input ready);
  modport sink   (input valid, desired_heading, integral_saturated, output ready);
endinterface

// ----- hdl/hand_position_heading_law.sv -----
// Hand-position heading law: a result is offered once the sequence for its accepted input
// transaction is done, and the next input is taken only after the previous result
// transaction has been accepted by the result sink.
// The CORDIC unit rotates once per cycle, then a sequencer steps one shared
// 34x32 multiplier through the error, integrator, gain and correction products,
// one registered product per state; the 64-bit correction takes four partial products.
// Input ready stays low until the result transaction completes, so result stalls add
// directly to the item time.
module hand_position_heading_law
  import hphl_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  hphl_in_if.sink     in_ch,
  hphl_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  state_t state_r, state_nxt;

  logic [23:0] dist_r, kp_r, ki_r;
  logic signed [47:0] integ_r, integ_nxt;
  logic signed [15:0] brg_r;
  logic signed [31:0] xt_r;
  logic [23:0] dt_r;
  logic signed [15:0] delta;
  logic signed [17:0] sn, cs;
  logic signed [17:0] cs_r;
  logic cord_start, cord_done;
  logic signed [33:0] ey_r, ey_nxt;
  logic signed [63:0] acc_r, acc_nxt;
  logic signed [31:0] ih_r;
  logic signed [33:0] mop_a;
  logic signed [31:0] mop_b;
  logic signed [65:0] mprod;
  logic signed [48:0] sum;
  logic signed [47:0] il;
  logic sat_r, sat_nxt;
  logic signed [15:0] dh_r, dh_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [31:0] corr_sum;

  assign delta = in_ch.vehicle_heading - in_ch.path_bearing;
  assign cord_start = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE) && !out_valid_r;

  hphl_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk, .rst_n, .start(cord_start), .angle(delta),
    .done(cord_done), .sin_q16(sn), .cos_q16(cs)
  );

  hphl_mul u_mul (.clk, .op_a(mop_a), .op_b(mop_b), .prod(mprod));

  assign il = integ_r - (48'(ih_r) <<< 16);
  assign sum = 49'(integ_r) + 49'(mprod >>> 16);

  always_comb begin
    mop_a = '0;
    mop_b = '0;
    unique case (state_r)
      ST_DSIN: begin mop_a = 34'($signed({1'b0, dist_r})); mop_b = 32'(sn); end
      ST_INC:  begin mop_a = ey_r; mop_b = 32'($signed({1'b0, dt_r})); end
      ST_PROP: begin mop_a = ey_r; mop_b = 32'($signed({1'b0, kp_r})); end
      ST_IHI:  begin mop_a = 34'(ih_r); mop_b = 32'($signed({1'b0, ki_r})); end
      ST_ILO:  begin mop_a = 34'(il); mop_b = 32'($signed({1'b0, ki_r})); end
      ST_UCL:  begin mop_a = $signed({2'b0, acc_r[31:0]}); mop_b = 32'(cs_r); end
      ST_UCH:  begin mop_a = 34'($signed(acc_r[63:32])); mop_b = 32'(cs_r); end
      ST_WKL: begin
        mop_a = $signed({2'b0, acc_r[31:0]});
        mop_b = $signed({2'b0, RadToBaQ16});
      end
      ST_WKH: begin
        mop_a = 34'($signed(acc_r[63:32]));
        mop_b = $signed({2'b0, RadToBaQ16});
      end
      default: begin mop_a = '0; mop_b = '0; end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    integ_nxt = integ_r;
    ey_nxt = ey_r;
    acc_nxt = acc_r;
    sat_nxt = sat_r;
    dh_nxt = dh_r;
    out_valid_nxt = out_valid_r;
    corr_sum = acc_r[63:32] + mprod[31:0];
    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE:   if (cord_start) state_nxt = ST_CORDIC;
      ST_CORDIC: if (cord_done) state_nxt = ST_DSIN;
      ST_DSIN:   state_nxt = ST_EY;
      ST_EY: begin
        ey_nxt = 34'(xt_r) + 34'(mprod >>> 16);
        state_nxt = ST_INC;
      end
      ST_INC:    state_nxt = ST_INTEG;
      ST_INTEG: begin
        sat_nxt = 1'b0;
        if (sum > 49'(IntMax48)) begin
          integ_nxt = IntMax48; sat_nxt = 1'b1;
        end else if (sum < 49'(IntMin48)) begin
          integ_nxt = IntMin48; sat_nxt = 1'b1;
        end else begin
          integ_nxt = sum[47:0];
        end
        state_nxt = ST_PROP;
      end
      ST_PROP:   state_nxt = ST_IHI;
      ST_IHI: begin
        acc_nxt = 64'(mprod >>> 16);
        state_nxt = ST_ILO;
      end
      ST_ILO: begin
        acc_nxt = acc_r + 64'(mprod);
        state_nxt = ST_U;
      end
      ST_U: begin
        acc_nxt = acc_r + 64'(mprod >>> 16);
        state_nxt = ST_UCL;
      end
      ST_UCL:    state_nxt = ST_UCH;
      ST_UCH: begin
        acc_nxt = mprod[63:0];
        state_nxt = ST_WKL;
      end
      ST_WKL: begin
        acc_nxt = acc_r + {mprod[31:0], 32'b0};
        state_nxt = ST_WKH;
      end
      ST_WKH: begin
        acc_nxt = mprod[63:0];
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        dh_nxt = brg_r - corr_sum[31:16];
        out_valid_nxt = 1'b1;
        state_nxt = ST_IDLE;
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_valid_r <= 1'b0;
      integ_r <= '0;
      dist_r <= 24'd65536;
      kp_r <= 24'd13107;
      ki_r <= 24'd655;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
      integ_r <= integ_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_LOOKAHEAD: dist_r <= cfg_data;
          CFG_PROP_GAIN: kp_r <= cfg_data;
          CFG_INT_GAIN:  ki_r <= cfg_data;
          default: ;
        endcase
      end
    end
    ey_r <= ey_nxt;
    acc_r <= acc_nxt;
    sat_r <= sat_nxt;
    dh_r <= dh_nxt;
    if (cord_start) begin
      brg_r <= in_ch.path_bearing;
      xt_r <= in_ch.cross_track;
      dt_r <= in_ch.elapsed_time;
    end
    if (state_r == ST_DSIN) cs_r <= cs;
    if (state_r == ST_PROP) ih_r <= 32'(integ_r >>> 16);
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.desired_heading = dh_r;
  assign out_ch.integral_saturated = sat_r;

endmodule

// ----- hdl/hphl_cordic.sv -----
// Iterative CORDIC giving Q16 sine and cosine of a 16-bit binary angle.
module hphl_cordic
  import hphl_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [15:0] angle,
  output logic               done,
  output logic signed [17:0] sin_q16,
  output logic signed [17:0] cos_q16
);

  localparam int StepW = $clog2(CORDIC_STEPS + 1);

  logic signed [33:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [33:0] z_r, z_nxt;
  logic               neg_r, neg_nxt;
  logic [StepW-1:0]   step_r, step_nxt;
  logic               busy_r, busy_nxt;
  logic signed [33:0] xs, ys, at, z0;
  logic signed [33:0] cr, sr;

  function automatic logic signed [17:0] to_q16(input logic signed [33:0] v);
    logic signed [33:0] r;
    begin
      r = (v + 34'sd8192) >>> 14;
      if (r > 34'sd65536) r = 34'sd65536;
      if (r < -34'sd65536) r = -34'sd65536;
      return r[17:0];
    end
  endfunction

  always_comb begin
    xs = x_r >>> step_r;
    ys = y_r >>> step_r;
    at = 34'($unsigned(atan_turn32(5'(step_r))));
    z0 = 34'(angle) <<< 16;
    x_nxt = x_r;
    y_nxt = y_r;
    z_nxt = z_r;
    neg_nxt = neg_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    if (start) begin
      x_nxt = CordicX0;
      y_nxt = '0;
      step_nxt = '0;
      busy_nxt = 1'b1;
      neg_nxt = 1'b0;
      z_nxt = z0;
      if (z0 > (34'sd1 <<< 30)) begin
        z_nxt = z0 - (34'sd1 <<< 31);
        neg_nxt = 1'b1;
      end else if (z0 < -(34'sd1 <<< 30)) begin
        z_nxt = z0 + (34'sd1 <<< 31);
        neg_nxt = 1'b1;
      end
    end else if (busy_r) begin
      if (!z_r[33]) begin
        x_nxt = x_r - ys;
        y_nxt = y_r + xs;
        z_nxt = z_r - at;
      end else begin
        x_nxt = x_r + ys;
        y_nxt = y_r - xs;
        z_nxt = z_r + at;
      end
      step_nxt = step_r + 1'b1;
      if (step_r == StepW'(CORDIC_STEPS - 1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
    neg_r <= neg_nxt;
  end

  always_comb begin
    cr = 34'(to_q16(x_r));
    sr = 34'(to_q16(y_r));
    if (neg_r) begin
      cr = -cr;
      sr = -sr;
    end
    cos_q16 = cr[17:0];
    sin_q16 = sr[17:0];
  end

  assign done = busy_r && (step_r == StepW'(CORDIC_STEPS - 1));

endmodule

// ----- hdl/hphl_mul.sv -----
// Shared registered signed multiplier, 34 by 32 bits.
module hphl_mul (
  input  logic               clk,
  input  logic signed [33:0] op_a,
  input  logic signed [31:0] op_b,
  output logic signed [65:0] prod
);

  logic signed [65:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

  assign prod = prod_r;

endmodule
